// File: hw/rtl/wgba_pkg.sv
// wgba_pkg: shared widths and command codes for the width generic bit alu
// no dependencies; used by the channel interfaces and the alu core
package wgba_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned OPW_W  = 7;
  localparam int unsigned DATA_W = 64;

  // codes six and seven are not named and flag as undefined
  typedef enum logic [CMD_W-1:0] {
    CMD_ABS      = 3'd0,
    CMD_MIN      = 3'd1,
    CMD_MAX      = 3'd2,
    CMD_POPCOUNT = 3'd3,
    CMD_CLZ      = 3'd4,
    CMD_CTZ      = 3'd5
  } cmd_e;

endpackage

// File: hw/rtl/wgba_in_if.sv
// wgba_in_if: valid/ready channel carrying one operation beat into the alu
// depends on wgba_pkg for field widths
interface wgba_in_if;
  logic                               valid;
  logic                               ready;
  logic        [wgba_pkg::CMD_W-1:0]  command;
  logic        [wgba_pkg::OPW_W-1:0]  operand_width;
  logic signed [wgba_pkg::DATA_W-1:0] operand_a;
  logic signed [wgba_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, output command, output operand_width,
                  output operand_a, output operand_b, input ready);
  modport sink   (input valid, input command, input operand_width,
                  input operand_a, input operand_b, output ready);
endinterface

// File: hw/rtl/wgba_out_if.sv
// wgba_out_if: valid/ready channel carrying one result beat out of the alu
// depends on wgba_pkg for field widths
interface wgba_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wgba_pkg::DATA_W-1:0] result_value;
  logic                               undefined_flag;

  modport source (output valid, output result_value, output undefined_flag,
                  input ready);
  modport sink   (input valid, input result_value, input undefined_flag,
                  output ready);
endinterface

// File: hw/rtl/wgba_bit_count.sv
// wgba_bit_count: population count, leading and trailing zero count of a masked word
// no package dependency; instantiated by width_generic_bit_alu_core
module wgba_bit_count #(
  parameter int unsigned W  = 64,
  parameter int unsigned NW = 7,
  parameter int unsigned IW = 6
) (
  input  logic [W-1:0]  u_i,
  input  logic [NW-1:0] n_m1_i,
  output logic [NW-1:0] pop_cnt_o,
  output logic [NW-1:0] lead_cnt_o,
  output logic [NW-1:0] trail_cnt_o
);

  logic [IW-1:0] msb_idx;
  logic [IW-1:0] lsb_idx;

  assign pop_cnt_o = NW'($countones(u_i));

  // highest set bit wins
  always_comb begin
    msb_idx = '0;
    for (int i = 0; i < W; i++) begin
      if (u_i[i]) begin
        msb_idx = IW'(i);
      end
    end
  end

  // lowest set bit wins
  always_comb begin
    lsb_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (u_i[i]) begin
        lsb_idx = IW'(i);
      end
    end
  end

  assign lead_cnt_o  = n_m1_i - NW'(msb_idx);
  assign trail_cnt_o = NW'(lsb_idx);

endmodule

// File: hw/rtl/width_generic_bit_alu_core.sv
// width_generic_bit_alu_core: abs, min, max, popcount, clz, ctz within a width of 1 to 64
// path: an accepted input beat passes through the input register, then the result register, to out_o
// throughput: one beat per cycle while out_o is not stalled, set by the input register and result register pair
// a result waiting on a stalled out_o holds off input only once the input register is full
// reset: rst_ni asynchronous active low, clears both stage valid bits only
// depends on wgba_pkg, wgba_in_if, wgba_out_if and wgba_bit_count
module width_generic_bit_alu_core #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wgba_in_if.sink     in_i,
  wgba_out_if.source  out_o
);

  // operands only matter up to the largest width, so the datapath is that wide
  localparam int unsigned W  = MAX_WIDTH;
  localparam int unsigned NW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned IW = $clog2(MAX_WIDTH);

  // ---------------------------------------------------------------------
  // handshake: two-entry pipeline, each stage advances when the next frees
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s2_ready;

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------------
  // input register, payload only
  // ---------------------------------------------------------------------
  logic [wgba_pkg::CMD_W-1:0] cmd_q;
  logic [wgba_pkg::OPW_W-1:0] width_q;
  logic [W-1:0]               a_q;
  logic [W-1:0]               b_q;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_q   <= in_i.command;
      width_q <= in_i.operand_width;
      a_q     <= in_i.operand_a[W-1:0];
      b_q     <= in_i.operand_b[W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // width clamp: zero acts as one, anything above the maximum saturates
  // ---------------------------------------------------------------------
  logic [NW-1:0] n_w;
  logic [NW-1:0] n_m1;
  logic [IW-1:0] sign_idx;

  always_comb begin
    if (width_q == '0) begin
      n_w = NW'(1);
    end else if (width_q > wgba_pkg::OPW_W'(MAX_WIDTH)) begin
      n_w = NW'(MAX_WIDTH);
    end else begin
      n_w = width_q[NW-1:0];
    end
  end

  assign n_m1     = n_w - NW'(1);
  assign sign_idx = n_m1[IW-1:0];

  // ---------------------------------------------------------------------
  // width mask and sign extension of both operands from bit n-1
  // ---------------------------------------------------------------------
  logic [W-1:0] mask;
  logic [W-1:0] a_ext;
  logic [W-1:0] b_ext;
  logic [W-1:0] u_a;
  logic         a_sign;
  logic         b_sign;

  assign a_sign = a_q[sign_idx];
  assign b_sign = b_q[sign_idx];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i]  = (NW'(i) < n_w);
      a_ext[i] = mask[i] ? a_q[i] : a_sign;
      b_ext[i] = mask[i] ? b_q[i] : b_sign;
    end
  end

  assign u_a = a_ext & mask;

  // ---------------------------------------------------------------------
  // counting unit on the masked first operand
  // ---------------------------------------------------------------------
  logic [NW-1:0] pop_cnt;
  logic [NW-1:0] lead_cnt;
  logic [NW-1:0] trail_cnt;

  wgba_bit_count #(
    .W  (W),
    .NW (NW),
    .IW (IW)
  ) u_bit_count (
    .u_i         (u_a),
    .n_m1_i      (n_m1),
    .pop_cnt_o   (pop_cnt),
    .lead_cnt_o  (lead_cnt),
    .trail_cnt_o (trail_cnt)
  );

  // ---------------------------------------------------------------------
  // operation select
  // ---------------------------------------------------------------------
  logic [W-1:0] most_neg;     // 1 << (n-1) within the mask
  logic [W-1:0] pos_limit;    // mask >> 1
  logic         a_less_b;
  logic [W-1:0] res_w;
  logic         undef;

  assign most_neg  = mask ^ (mask >> 1);
  assign pos_limit = mask >> 1;
  assign a_less_b  = $signed(a_ext) < $signed(b_ext);

  always_comb begin
    res_w = '0;
    undef = 1'b0;
    case (cmd_q)
      wgba_pkg::CMD_ABS: begin
        if (u_a == most_neg) begin
          undef = 1'b1;
        end else begin
          res_w = a_ext[W-1] ? (W'(0) - a_ext) : a_ext;
        end
      end
      wgba_pkg::CMD_MIN: begin
        res_w = a_less_b ? a_ext : b_ext;
      end
      wgba_pkg::CMD_MAX: begin
        // ties take b, as does a less than b
        res_w = ($signed(b_ext) < $signed(a_ext)) ? a_ext : b_ext;
      end
      wgba_pkg::CMD_POPCOUNT: begin
        // only widths of one or two can overflow the signed range
        if (W'(pop_cnt) > pos_limit) begin
          undef = 1'b1;
        end else begin
          res_w = W'(pop_cnt);
        end
      end
      wgba_pkg::CMD_CLZ: begin
        if (u_a == '0) begin
          undef = 1'b1;
        end else begin
          res_w = W'(lead_cnt);
        end
      end
      wgba_pkg::CMD_CTZ: begin
        if (u_a == '0) begin
          undef = 1'b1;
        end else begin
          res_w = W'(trail_cnt);
        end
      end
      default: begin
        undef = 1'b1;
      end
    endcase
  end

  // result sign-extended from bit n-1, then to the full port width
  logic [W-1:0] res_ext;
  logic         res_sign;

  assign res_sign = res_w[sign_idx];

  always_comb begin
    for (int i = 0; i < W; i++) begin
      res_ext[i] = mask[i] ? res_w[i] : res_sign;
    end
  end

  // ---------------------------------------------------------------------
  // result register, payload only
  // ---------------------------------------------------------------------
  logic [wgba_pkg::DATA_W-1:0] res_q;
  logic                        undef_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      res_q   <= wgba_pkg::DATA_W'($signed(res_ext));
      undef_q <= undef;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result_value   = res_q;
  assign out_o.undefined_flag = undef_q;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for width_generic_bit_alu_core, driving operation beats
// and checking every result beat against an in-bench model; depends on wgba_pkg,
// wgba_in_if, wgba_out_if and the alu core
module tb_top;

  localparam int unsigned ALU_MAX_WIDTH = 64;
  localparam int unsigned RANDOM_OPS    = 500;
  localparam int unsigned DRAIN_CYCLES  = 10;    // longer than the path through the input and result registers
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no beat on either side
  localparam int unsigned REPORT_LIMIT  = 10;

  // codes the core does not name, both must flag as undefined
  localparam logic [wgba_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [wgba_pkg::CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  localparam logic [wgba_pkg::DATA_W-1:0] SMIN64 = 64'h8000_0000_0000_0000;
  localparam logic [wgba_pkg::DATA_W-1:0] SMAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [wgba_pkg::CMD_W-1:0]  cmd;
    logic [wgba_pkg::OPW_W-1:0]  opw;
    logic [wgba_pkg::DATA_W-1:0] a;
    logic [wgba_pkg::DATA_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic [wgba_pkg::DATA_W-1:0] value;
    logic                        undef;
  } alu_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wgba_in_if  in_if ();
  wgba_out_if out_if ();

  width_generic_bit_alu_core #(
    .MAX_WIDTH(ALU_MAX_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // operations waiting to be driven, results waiting to come back
  alu_op_t     pending_ops_q[$];
  alu_result_t awaited_results_q[$];

  int unsigned ops_total      = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  bit          timed_out      = 1'b0;

  // beat taken at the last rising edge, read by the falling-edge drivers
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  // ---------------------------------------------------------------------------
  // alu model
  // ---------------------------------------------------------------------------

  // keep the low n bits and copy bit n-1 upward
  function automatic logic [wgba_pkg::DATA_W-1:0] sext_width(
      logic [wgba_pkg::DATA_W-1:0] v, int unsigned n);
    logic [wgba_pkg::DATA_W-1:0] msk;
    msk = (n >= wgba_pkg::DATA_W) ? '1 : ((64'd1 << n) - 64'd1);
    v   = v & msk;
    if (v[n-1]) v = v | ~msk;
    return v;
  endfunction

  function automatic alu_result_t compute_alu_result(alu_op_t op);
    int unsigned                 n;
    int unsigned                 cnt;
    int                          i;
    logic [wgba_pkg::DATA_W-1:0] msk;
    logic [wgba_pkg::DATA_W-1:0] a;
    logic [wgba_pkg::DATA_W-1:0] b;
    logic [wgba_pkg::DATA_W-1:0] u;
    logic [wgba_pkg::DATA_W-1:0] res;
    bit                          ub;
    alu_result_t                 r;
    // width zero acts as one, oversized widths saturate
    n = 32'(op.opw);
    if (n == 0) n = 1;
    else if (n > ALU_MAX_WIDTH) n = ALU_MAX_WIDTH;
    msk = (n >= wgba_pkg::DATA_W) ? '1 : ((64'd1 << n) - 64'd1);
    a   = sext_width(op.a, n);
    b   = sext_width(op.b, n);
    u   = a & msk;
    res = '0;
    ub  = 1'b0;
    cnt = 0;
    case (op.cmd)
      wgba_pkg::CMD_ABS: begin
        // most negative value has no positive twin
        if (u == (64'd1 << (n - 1))) ub = 1'b1;
        else res = a[wgba_pkg::DATA_W-1] ? -a : a;
      end
      wgba_pkg::CMD_MIN: begin
        res = ($signed(a) < $signed(b)) ? a : b;
      end
      wgba_pkg::CMD_MAX: begin
        res = ($signed(b) < $signed(a)) ? a : b;
      end
      wgba_pkg::CMD_POPCOUNT: begin
        // count must fit the signed range of n bits
        cnt = $countones(u);
        if (cnt > (msk >> 1)) ub = 1'b1;
        else res = wgba_pkg::DATA_W'(cnt);
      end
      wgba_pkg::CMD_CLZ: begin
        if (u == '0) begin
          ub = 1'b1;
        end else begin
          for (i = n - 1; i >= 0 && !u[i]; i--) cnt++;
          res = wgba_pkg::DATA_W'(cnt);
        end
      end
      wgba_pkg::CMD_CTZ: begin
        if (u == '0) begin
          ub = 1'b1;
        end else begin
          for (i = 0; i < n && !u[i]; i++) cnt++;
          res = wgba_pkg::DATA_W'(cnt);
        end
      end
      default: begin
        ub = 1'b1;
      end
    endcase
    if (ub) res = '0;
    r.value = sext_width(res, n);
    r.undef = ub;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_op(logic [wgba_pkg::CMD_W-1:0] cmd, logic [wgba_pkg::OPW_W-1:0] opw,
                        logic [wgba_pkg::DATA_W-1:0] a, logic [wgba_pkg::DATA_W-1:0] b);
    alu_op_t op;
    op.cmd = cmd;
    op.opw = opw;
    op.a   = a;
    op.b   = b;
    pending_ops_q.push_back(op);
    ops_total++;
  endtask

  // operand shapes that hit the corners of every command at width n,
  // most with random junk above bit n-1 that the core must drop
  function automatic logic [wgba_pkg::DATA_W-1:0] pick_operand(int unsigned n);
    logic [wgba_pkg::DATA_W-1:0] junk;
    junk = {$urandom, $urandom} << n;
    case ($urandom_range(0, 9))
      0:       return junk;
      1:       return '1;
      2:       return (64'd1 << $urandom_range(0, n - 1)) | junk;
      3:       return (64'd1 << (n - 1)) | junk;
      4:       return -wgba_pkg::DATA_W'($urandom_range(1, 8));
      5:       return wgba_pkg::DATA_W'($urandom_range(0, 15)) | junk;
      6:       return sext_width({$urandom, $urandom} >> $urandom_range(0, 63), n);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // wait drawn per beat; now and then switch into or out of a no-idle stretch
  function automatic int unsigned pick_wait(inout bit steady);
    if ($urandom_range(0, 15) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic note_mismatch(string what, logic [wgba_pkg::DATA_W-1:0] want,
                               logic [wgba_pkg::DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("mismatch on %0s at %0t: expected %h, got %h", what, $realtime, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // input driver, changes at the falling edge
  // ---------------------------------------------------------------------------

  alu_op_t     drv_op;
  int unsigned in_gap_left = 0;
  bit          in_steady   = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      // slot is free: either idle for the drawn gap or present the next beat
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_if.valid     <= 1'b0;
        in_if.operand_a <= {$urandom, $urandom};  // junk while not valid
      end else if (pending_ops_q.size() > 0) begin
        drv_op = pending_ops_q.pop_front();
        in_if.valid         <= 1'b1;
        in_if.command       <= drv_op.cmd;
        in_if.operand_width <= drv_op.opw;
        in_if.operand_a     <= drv_op.a;
        in_if.operand_b     <= drv_op.b;
        in_gap_left = pick_wait(in_steady);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink ready, changes at the falling edge
  // ---------------------------------------------------------------------------

  int unsigned out_stall_left = 0;
  bit          out_steady     = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_fire) out_stall_left = pick_wait(out_steady);
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // beat sampling at the rising edge: predict, check, watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : beat_sampler
    alu_op_t     taken;
    alu_result_t want;
    in_fire  <= rst_ni && in_if.valid && in_if.ready;
    out_fire <= rst_ni && out_if.valid && out_if.ready;
    if (rst_ni) begin
      // prediction first so the result order never depends on process order
      if (in_if.valid && in_if.ready) begin
        taken.cmd = in_if.command;
        taken.opw = in_if.operand_width;
        taken.a   = in_if.operand_a;
        taken.b   = in_if.operand_b;
        awaited_results_q.push_back(compute_alu_result(taken));
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (awaited_results_q.size() == 0) begin
          note_mismatch("result beat with nothing pending", '0, out_if.result_value);
        end else begin
          want = awaited_results_q.pop_front();
          if (out_if.result_value !== want.value)
            note_mismatch("result_value", want.value, out_if.result_value);
          if (out_if.undefined_flag !== want.undef)
            note_mismatch("undefined_flag", wgba_pkg::DATA_W'(want.undef),
                          wgba_pkg::DATA_W'(out_if.undefined_flag));
        end
      end
      // nothing moving on either side for too long
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) timed_out = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned                 k;
    int unsigned                 n_eff;
    logic [wgba_pkg::CMD_W-1:0]  cmd;
    logic [wgba_pkg::OPW_W-1:0]  opw;
    logic [wgba_pkg::DATA_W-1:0] a;
    logic [wgba_pkg::DATA_W-1:0] b;

    in_if.valid         = 1'b0;
    in_if.command       = '0;
    in_if.operand_width = '0;
    in_if.operand_a     = '0;
    in_if.operand_b     = '0;
    out_if.ready        = 1'b0;

    // abs: most negative flags at full width, width one and with junk above
    add_op(wgba_pkg::CMD_ABS, 64, SMIN64, 0);
    add_op(wgba_pkg::CMD_ABS, 64, -1, {$urandom, $urandom});
    add_op(wgba_pkg::CMD_ABS, 64, SMAX64, 0);
    add_op(wgba_pkg::CMD_ABS, 1, 1, 0);
    add_op(wgba_pkg::CMD_ABS, 1, 0, -1);
    add_op(wgba_pkg::CMD_ABS, 8, 64'hABCD_EF01_2345_6780, 0);
    // min / max at the extremes, width zero and oversized width
    add_op(wgba_pkg::CMD_MIN, 64, SMAX64, SMIN64);
    add_op(wgba_pkg::CMD_MAX, 64, SMAX64, SMIN64);
    add_op(wgba_pkg::CMD_MIN, 0, 1, 0);
    add_op(wgba_pkg::CMD_MAX, 127, -5, 7);
    add_op(wgba_pkg::CMD_MAX, 16, 64'h8000, 64'h7FFF);
    add_op(wgba_pkg::CMD_MIN, 33, 42, 42);
    // popcount overflowing the signed range at widths one and two
    add_op(wgba_pkg::CMD_POPCOUNT, 1, 1, 0);
    add_op(wgba_pkg::CMD_POPCOUNT, 2, 3, 0);
    add_op(wgba_pkg::CMD_POPCOUNT, 2, 1, 0);
    add_op(wgba_pkg::CMD_POPCOUNT, 64, -1, 0);
    add_op(wgba_pkg::CMD_POPCOUNT, 64, 0, -1);
    // clz / ctz of zero, including zero only in the low n bits
    add_op(wgba_pkg::CMD_CLZ, 64, 0, 0);
    add_op(wgba_pkg::CMD_CLZ, 64, 1, 0);
    add_op(wgba_pkg::CMD_CLZ, 13, 64'd1 << 20, 0);
    add_op(wgba_pkg::CMD_CLZ, 3, 64'hFFFF_FFFF_FFFF_FFFC, 0);
    add_op(wgba_pkg::CMD_CTZ, 64, SMIN64, 0);
    add_op(wgba_pkg::CMD_CTZ, 7, 0, 0);
    add_op(wgba_pkg::CMD_CTZ, 0, 1, 0);
    // unnamed commands
    add_op(CMD_RSVD_LO, 32, 5, 5);
    add_op(CMD_RSVD_HI, 100, -1, -1);

    for (k = 0; k < RANDOM_OPS; k++) begin
      if ($urandom_range(0, 15) == 0)
        cmd = wgba_pkg::CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
      else cmd = wgba_pkg::CMD_W'($urandom_range(wgba_pkg::CMD_ABS, wgba_pkg::CMD_CTZ));
      case ($urandom_range(0, 9))
        0:       opw = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(65, 127));
        1, 2:    opw = wgba_pkg::OPW_W'($urandom_range(1, 8));
        3: begin
          case ($urandom_range(0, 3))
            0:       opw = 1;
            1:       opw = 2;
            2:       opw = 63;
            default: opw = 64;
          endcase
        end
        default: opw = wgba_pkg::OPW_W'($urandom_range(1, 64));
      endcase
      n_eff = (opw == 0) ? 1 : ((opw > ALU_MAX_WIDTH) ? ALU_MAX_WIDTH : 32'(opw));
      a = pick_operand(n_eff);
      // equal operands now and then so min / max ties get covered
      b = ($urandom_range(0, 7) == 0) ? a : pick_operand(n_eff);
      add_op(cmd, opw, a, b);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (results_seen >= ops_total || timed_out);
    // let any stray extra beat show up before judging
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!timed_out && mismatch_count == 0 && awaited_results_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
